FILE: rtl/rdc_pkg.sv
// shared types, constants and the microcode program of the radix digit converter
// no dependencies; imported by rdc_datapath and radix_digit_converter
`default_nettype none

package rdc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int STACK_DEPTH = 32;
	localparam int BASE_WIDTH  = 5;
	localparam int DIGIT_WIDTH = 4;
	localparam int BIT_WIDTH   = $clog2(VALUE_WIDTH);
	localparam int SP_WIDTH    = $clog2(STACK_DEPTH + 1);
	localparam int IDX_WIDTH   = $clog2(STACK_DEPTH);

	localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_WIDTH'(2);
	localparam logic [BASE_WIDTH-1:0] BASE_MIN   = BASE_WIDTH'(2);
	localparam logic [BASE_WIDTH-1:0] BASE_MAX   = BASE_WIDTH'(16);

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_SIGN     = 3'd1;
	localparam step_t STEP_DIV_INIT = 3'd2;
	localparam step_t STEP_DIV_STEP = 3'd3;
	localparam step_t STEP_PUSH     = 3'd4;
	localparam step_t STEP_POP      = 3'd5;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_SIGN,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_PUSH,
		ACT_POP
	} act_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_IN,
		WAIT_SIGN_SLOT,
		WAIT_SLOT
	} wait_t;

	typedef enum logic [1:0] {
		BR_NEVER,
		BR_DIV_BUSY,
		BR_MAG_NZ,
		BR_SP_MORE
	} br_t;

	typedef struct packed {
		wait_t wt;
		act_t  act;
		br_t   br;
		step_t br_to;
		step_t next;
	} ucode_t;

	// control from sequencer to datapath
	typedef struct packed {
		act_t act;
	} ctrl_t;

	// status from datapath back to sequencer
	typedef struct packed {
		logic slot_free;
		logic neg;
		logic mag_zero;
		logic div_done;
		logic sp_last;
	} status_t;

	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		w = '{wt: WAIT_IN, act: ACT_NONE, br: BR_NEVER, br_to: STEP_IDLE, next: STEP_IDLE};
		unique case (pc)
			STEP_IDLE:     w = '{WAIT_IN,        ACT_LOAD,     BR_NEVER,    STEP_IDLE,
				STEP_SIGN};
			STEP_SIGN:     w = '{WAIT_SIGN_SLOT, ACT_SIGN,     BR_NEVER,    STEP_IDLE,
				STEP_DIV_INIT};
			STEP_DIV_INIT: w = '{WAIT_NONE,      ACT_DIV_INIT, BR_NEVER,    STEP_IDLE,
				STEP_DIV_STEP};
			STEP_DIV_STEP: w = '{WAIT_NONE,      ACT_DIV_STEP, BR_DIV_BUSY, STEP_DIV_STEP,
				STEP_PUSH};
			STEP_PUSH:     w = '{WAIT_NONE,      ACT_PUSH,     BR_MAG_NZ,   STEP_DIV_INIT,
				STEP_POP};
			STEP_POP:      w = '{WAIT_SLOT,      ACT_POP,      BR_SP_MORE,  STEP_POP,
				STEP_IDLE};
			default:       w = '{WAIT_NONE,      ACT_NONE,     BR_NEVER,    STEP_IDLE,
				STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rdc_datapath.sv
// datapath: magnitude register, bit-serial divider, digit stack and output register
// depends on rdc_pkg
`default_nettype none

module rdc_datapath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  rdc_pkg::ctrl_t                       ctl,
	input  wire  [rdc_pkg::BASE_WIDTH-1:0]       eff_base,
	input  wire  signed [rdc_pkg::VALUE_WIDTH-1:0] value,
	input  wire                                  out_stall,
	output rdc_pkg::status_t                     st,
	output logic                                 out_valid,
	output logic                                 is_sign,
	output logic [rdc_pkg::DIGIT_WIDTH-1:0]      digit,
	output logic                                 last
);
	import rdc_pkg::*;

	localparam logic [BIT_WIDTH-1:0] BIT_LAST = BIT_WIDTH'(VALUE_WIDTH - 1);
	localparam logic [SP_WIDTH-1:0]  SP_FULL  = SP_WIDTH'(STACK_DEPTH);
	localparam logic [SP_WIDTH-1:0]  SP_ONE   = SP_WIDTH'(1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [DIGIT_WIDTH-1:0] rem_q;
	logic [BIT_WIDTH-1:0]   bit_q;
	logic [SP_WIDTH-1:0]    sp_q;
	logic [DIGIT_WIDTH-1:0] stack_q [STACK_DEPTH];

	logic                   out_valid_q;
	logic                   is_sign_q;
	logic [DIGIT_WIDTH-1:0] digit_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] v_u;
	logic [VALUE_WIDTH-1:0] v_mag;
	logic [BASE_WIDTH-1:0]  trial;
	logic                   ge;
	logic [BASE_WIDTH-1:0]  diff;
	logic [SP_WIDTH-1:0]    sp_dec;

	always_comb begin
		v_u    = value;
		v_mag  = v_u[VALUE_WIDTH-1] ? (~v_u + 1'b1) : v_u;
		// one restoring division step: shift the next dividend bit into the remainder
		trial  = {rem_q, mag_q[VALUE_WIDTH-1]};
		ge     = trial >= eff_base;
		diff   = trial - eff_base;
		sp_dec = sp_q - SP_ONE;
	end

	assign st.slot_free = !out_valid_q || !out_stall;
	assign st.neg       = neg_q;
	assign st.mag_zero  = mag_q == '0;
	assign st.div_done  = bit_q == BIT_LAST;
	assign st.sp_last   = sp_q == SP_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			neg_q <= 1'b0;
			sp_q  <= '0;
			bit_q <= '0;
		end else begin
			unique case (ctl.act)
				ACT_LOAD: begin
					mag_q <= v_mag;
					neg_q <= v_u[VALUE_WIDTH-1];
					sp_q  <= '0;
				end
				ACT_DIV_INIT: begin
					bit_q <= '0;
				end
				ACT_DIV_STEP: begin
					mag_q <= {mag_q[VALUE_WIDTH-2:0], ge};
					bit_q <= bit_q + 1'b1;
				end
				ACT_PUSH: begin
					if (sp_q < SP_FULL) begin
						sp_q <= sp_q + 1'b1;
					end
				end
				ACT_POP: begin
					sp_q <= sp_dec;
				end
				default: begin
				end
			endcase
		end
	end

	// remainder and stack entries are payload
	always_ff @(posedge clk) begin
		if (ctl.act == ACT_DIV_INIT) begin
			rem_q <= '0;
		end else if (ctl.act == ACT_DIV_STEP) begin
			rem_q <= ge ? diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
		end
		if (ctl.act == ACT_PUSH && sp_q < SP_FULL) begin
			stack_q[sp_q[IDX_WIDTH-1:0]] <= rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctl.act == ACT_SIGN && neg_q) || ctl.act == ACT_POP) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == ACT_SIGN && neg_q) begin
			is_sign_q <= 1'b1;
			digit_q   <= '0;
			last_q    <= 1'b0;
		end else if (ctl.act == ACT_POP) begin
			is_sign_q <= 1'b0;
			digit_q   <= stack_q[sp_dec[IDX_WIDTH-1:0]];
			last_q    <= sp_q == SP_ONE;
		end
	end

	assign out_valid = out_valid_q;
	assign is_sign   = is_sign_q;
	assign digit     = digit_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_FULL)
		else $error("digit stack pointer beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.act == ACT_POP |-> sp_q != '0)
		else $error("pop from empty digit stack");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == ACT_POP || (ctl.act == ACT_SIGN && neg_q)) |-> st.slot_free)
		else $error("item emitted over an untaken result");
`endif

endmodule

`default_nettype wire

FILE: rtl/radix_digit_converter.sv
// top level: base register, microcode sequencer and the datapath instance
// depends on rdc_pkg and rdc_datapath
`default_nettype none

// Converts one signed 32-bit value per input item into digits in the base held
// in the base register (0 and 1 act as 2, 17 to 31 act as 16). A negative value
// first gives a sign result, then the digits of its magnitude, most significant
// first; zero gives the single digit 0, and the final digit carries last. Input
// is taken only between runs. A small microcode program steps a bit-serial
// divider: each digit takes one set-up, 32 division steps and one push, and
// the digits are then popped out, each waiting while the output stalls.
// Write the base only while idle.
module radix_digit_converter (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [rdc_pkg::BASE_WIDTH-1:0]         cfg_wdata,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire  signed [rdc_pkg::VALUE_WIDTH-1:0] value,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic                                   is_sign,
	output logic [rdc_pkg::DIGIT_WIDTH-1:0]        digit,
	output logic                                   last
);
	import rdc_pkg::*;

	logic [BASE_WIDTH-1:0] base_q;
	logic [BASE_WIDTH-1:0] eff_base;
	step_t                 pc_q;
	step_t                 pc_d;
	ucode_t                uc;
	logic                  go;
	logic                  taken;
	ctrl_t                 ctl;
	status_t               st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (base_q < BASE_MIN) begin
			eff_base = BASE_MIN;
		end else if (base_q > BASE_MAX) begin
			eff_base = BASE_MAX;
		end else begin
			eff_base = base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		uc = ucode_rom(pc_q);
		unique case (uc.wt)
			WAIT_NONE:      go = 1'b1;
			WAIT_IN:        go = in_valid;
			WAIT_SIGN_SLOT: go = !st.neg || st.slot_free;
			WAIT_SLOT:      go = st.slot_free;
			default:        go = 1'b0;
		endcase
		unique case (uc.br)
			BR_NEVER:    taken = 1'b0;
			BR_DIV_BUSY: taken = !st.div_done;
			BR_MAG_NZ:   taken = !st.mag_zero;
			BR_SP_MORE:  taken = !st.sp_last;
			default:     taken = 1'b0;
		endcase
		ctl.act = go ? uc.act : ACT_NONE;
		if (!go) begin
			pc_d = pc_q;
		end else if (taken) begin
			pc_d = uc.br_to;
		end else begin
			pc_d = uc.next;
		end
		in_stall = uc.wt != WAIT_IN;
	end

	rdc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.eff_base  (eff_base),
		.value     (value),
		.out_stall (out_stall),
		.st        (st),
		.out_valid (out_valid),
		.is_sign   (is_sign),
		.digit     (digit),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == STEP_SIGN)
		else $error("accepted item did not start a run");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_POP)
		else $error("step counter outside the program");
	a_last_pop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.act == ACT_POP && st.sp_last |=> pc_q == STEP_IDLE && out_valid && last)
		else $error("final digit did not end the run");
`endif

endmodule

`default_nettype wire
